>>> sv/sti_pkg.sv
// Shared types and codes for the sorted table insert, search and delete unit.
package sti_pkg;

   // Operation codes carried in the request word.
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_SEARCH = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   // Status codes carried in the response word.
   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   // Fixed widths of the response fields.
   localparam int POS_BITS   = 6;
   localparam int COUNT_BITS = 7;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [31:0] operand_value;
   } req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [POS_BITS-1:0]   position;
      logic [COUNT_BITS-1:0] entry_count;
   } rsp_type;

endpackage

>>> sv/sorted_table_insert_search_delete_unit.sv
// Top level of the sorted table unit: control sequencer around the entry RAM.
//
//   channel   direction  word                   handshake
//   req_      in         sti_pkg::req_type      req_valid / req_ready
//   rsp_      out        sti_pkg::rsp_type      rsp_valid / rsp_ready
//
// One word is in work at a time. Each halving of the binary search reads the
// middle entry (S_CHECK, S_MID); the final window is then read at its low end
// and, if needed, its high end (S_WLO, S_WHI) through the registered RAM read
// port. Insert and delete then move one entry per cycle through the RAM.
// Reset clears the live count and the control state; the RAM is not cleared.
// A finished response waits in the output register while the next request is
// taken; a new response waits for that register to drain.
module sorted_table_insert_search_delete_unit #(
   parameter int CAPACITY   = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sti_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sti_pkg::rsp_type rsp_data
);

   import sti_pkg::*;

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_MID, S_WLO, S_WHI, S_RESOLVE, S_UP, S_PUT, S_DN, S_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic [1:0]            op_ff, op_in;
   logic [VALUE_BITS-1:0] key_ff, key_in;
   logic [IW-1:0]         lo_ff, lo_in;
   logic [IW-1:0]         hi_ff, hi_in;
   logic [IW-1:0]         addr_ff, addr_in;
   logic [CW-1:0]         pos_ff, pos_in;
   logic                  match_ff, match_in;
   logic [1:0]            status_ff, status_in;

   logic                  wr_en;
   logic [IW-1:0]         wr_addr;
   logic [VALUE_BITS-1:0] wr_data;
   logic [VALUE_BITS-1:0] rd_data;

   logic [63:0]           operand_wide;
   logic [IW-1:0]         diff;
   logic [IW-1:0]         mid;
   logic [CW-1:0]         cnt_m1;
   logic                  key_le;
   logic                  key_eq;
   logic                  key_lt;
   logic                  rsp_load;
   logic [CW+POS_BITS-1:0]   pos_wide;
   logic [CW+COUNT_BITS-1:0] cnt_wide;

   sti_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr_in),
      .rd_data (rd_data)
   );

   // Operand sign extended, then wrapped to the stored value width.
   assign operand_wide = {{32{req_data.operand_value[31]}}, req_data.operand_value};

   // Signed compare of the held key against the entry just read.
   assign key_eq = (key_ff == rd_data);
   assign key_lt = ($signed(key_ff) < $signed(rd_data));
   assign key_le = key_lt | key_eq;

   assign diff   = hi_ff - lo_ff;
   assign mid    = lo_ff + (diff >> 1);
   assign cnt_m1 = count_ff - CW'(1);

   // Response fields at their fixed widths.
   assign pos_wide = {{POS_BITS{1'b0}}, pos_ff};
   assign cnt_wide = {{COUNT_BITS{1'b0}}, count_ff};

   // Sequencer next-state logic.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      addr_in      = addr_ff;
      pos_in       = pos_ff;
      match_in     = match_ff;
      status_in    = status_ff;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = rd_data;
      rsp_load     = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_data.opcode;
               key_in    = operand_wide[VALUE_BITS-1:0];
               lo_in     = '0;
               hi_in     = cnt_m1[IW-1:0];
               pos_in    = '0;
               match_in  = 1'b0;
               status_in = ST_NOT_FOUND;
               if (req_data.opcode == OP_INSERT) begin
                  if (count_ff == CW'(CAPACITY)) begin
                     status_in = ST_FULL;
                     state_in  = S_DONE;
                  end else if (count_ff == '0) begin
                     status_in = ST_DONE;
                     state_in  = S_PUT;
                  end else begin
                     state_in = S_CHECK;
                  end
               end else if (req_data.opcode == OP_SEARCH ||
                            req_data.opcode == OP_DELETE) begin
                  state_in = (count_ff == '0) ? S_DONE : S_CHECK;
               end else begin
                  state_in = S_DONE;
               end
            end
         end

         // Pick the next read: the middle entry, or the low end of a small window.
         S_CHECK: begin
            if (diff <= IW'(1)) begin
               addr_in  = lo_ff;
               state_in = S_WLO;
            end else begin
               addr_in  = mid;
               state_in = S_MID;
            end
         end

         // Middle entry is back: stop on a hit, else halve the window.
         S_MID: begin
            if (key_eq) begin
               pos_in   = CW'(addr_ff);
               match_in = 1'b1;
               state_in = S_RESOLVE;
            end else if (key_lt) begin
               hi_in    = addr_ff - IW'(1);
               state_in = S_CHECK;
            end else begin
               lo_in    = addr_ff + IW'(1);
               state_in = S_CHECK;
            end
         end

         // Low end of the final window.
         S_WLO: begin
            if (key_le) begin
               pos_in   = CW'(lo_ff);
               match_in = key_eq;
               state_in = S_RESOLVE;
            end else begin
               addr_in  = hi_ff;
               state_in = S_WHI;
            end
         end

         // High end of the final window; past it, the slot can never match.
         S_WHI: begin
            if (key_le) begin
               pos_in   = CW'(hi_ff);
               match_in = key_eq;
            end else begin
               pos_in   = CW'(hi_ff) + CW'(1);
               match_in = 1'b0;
            end
            state_in = S_RESOLVE;
         end

         // Position known: decide what the operation does with it.
         S_RESOLVE: begin
            if (op_ff == OP_INSERT) begin
               status_in = ST_DONE;
               if (pos_ff == count_ff) begin
                  state_in = S_PUT;
               end else begin
                  addr_in  = cnt_m1[IW-1:0];
                  state_in = S_UP;
               end
            end else if (!match_ff) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_DONE;
            end else begin
               status_in = ST_DONE;
               if (op_ff == OP_DELETE && (pos_ff + CW'(1)) < count_ff) begin
                  addr_in  = pos_ff[IW-1:0] + IW'(1);
                  state_in = S_DN;
               end else begin
                  if (op_ff == OP_DELETE) begin
                     count_in = cnt_m1;
                  end
                  state_in = S_DONE;
               end
            end
         end

         // Shift up: entry read last cycle moves one slot higher.
         S_UP: begin
            wr_en   = 1'b1;
            wr_addr = addr_ff + IW'(1);
            if (addr_ff == pos_ff[IW-1:0]) begin
               state_in = S_PUT;
            end else begin
               addr_in = addr_ff - IW'(1);
            end
         end

         // Store the new value in the opened slot.
         S_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff[IW-1:0];
            wr_data  = key_ff;
            count_in = count_ff + CW'(1);
            state_in = S_DONE;
         end

         // Shift down: entry read last cycle moves one slot lower.
         S_DN: begin
            wr_en   = 1'b1;
            wr_addr = addr_ff - IW'(1);
            if (CW'(addr_ff) == cnt_m1) begin
               count_in = cnt_m1;
               state_in = S_DONE;
            end else begin
               addr_in = addr_ff + IW'(1);
            end
         end

         // Hand the response to the output register once it is free.
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load           = 1'b1;
               rsp_valid_in       = 1'b1;
               rsp_in.status      = status_ff;
               rsp_in.position    = (status_ff == ST_DONE) ?
                                    pos_wide[POS_BITS-1:0] : '0;
               rsp_in.entry_count = cnt_wide[COUNT_BITS-1:0];
               state_in           = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      rsp_ff    <= rsp_in;
      op_ff     <= op_in;
      key_ff    <= key_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      addr_ff   <= addr_in;
      pos_ff    <= pos_in;
      match_ff  <= match_in;
      status_ff <= status_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The live count never passes the table capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("live count exceeds capacity");

   // An accepted word blocks the request side on the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   // A full status is only reported with the table at capacity.
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && status_ff == ST_FULL) |-> (count_ff == CW'(CAPACITY)))
      else $error("full status with room left");

   // Storing a new value raises the count by exactly one.
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUT) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("insert did not advance the count");

endmodule

>>> sv/sti_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module sti_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; a read of the entry written in the
   // same cycle returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> tb/tb_sorted_table_insert_search_delete_unit.sv
// Testbench for the sorted table unit: random words checked against a scoreboard.
`timescale 1ns / 100ps

module tb_sorted_table_insert_search_delete_unit;
   import sti_pkg::*;

   localparam int TABLE_DEPTH    = 64;
   localparam int RANDOM_WORDS   = 950;
   localparam int POOL_SIZE      = 12;
   localparam int LONG_HOLD      = 400;
   localparam int SETTLE_CYCLES  = 150;
   localparam int WATCHDOG_LIMIT = 3000;

   // The one opcode the unit does not act on.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [31:0] MIN_VALUE = 32'h8000_0000;
   localparam logic [31:0] MAX_VALUE = 32'h7fff_ffff;

   typedef enum int {ROUND_FILL, ROUND_DRAIN, ROUND_MIXED} round_kind;

   // Scoreboard: mirrors the sorted table and holds the responses still owed.
   class table_scoreboard;
      logic signed [31:0] entries [TABLE_DEPTH];
      int      live;
      rsp_type owed_q[$];
      int      errors;
      int      n_insert, n_search, n_delete, n_unused;
      int      n_full, n_miss, n_hit, peak_fill, n_empty_visits;

      function new();
         live = 0;
         errors = 0;
      endfunction

      // Binary search with early exit on a middle hit, then a two-entry window.
      function int locate(logic signed [31:0] v);
         int lo;
         int hi;
         int mid;
         lo = 0;
         hi = live - 1;
         while (hi - lo >= 2) begin
            mid = lo + (hi - lo) / 2;
            if (v == entries[mid]) return mid;
            if (v < entries[mid]) hi = mid - 1;
            else lo = mid + 1;
         end
         if (v <= entries[lo]) return lo;
         if (v <= entries[hi]) return hi;
         return hi + 1;
      endfunction

      // Apply one accepted request word to the mirror and queue its response.
      function void note_request(req_type w);
         rsp_type r;
         int slot;
         int i;
         logic signed [31:0] v;
         v = w.operand_value;
         r.status = ST_NOT_FOUND;
         r.position = '0;
         case (w.opcode)
            OP_INSERT: begin
               n_insert++;
               if (live >= TABLE_DEPTH) begin
                  r.status = ST_FULL;
                  n_full++;
               end else begin
                  slot = (live == 0) ? 0 : locate(v);
                  for (i = live; i > slot; i--) entries[i] = entries[i-1];
                  entries[slot] = v;
                  live++;
                  r.status = ST_DONE;
                  r.position = slot[POS_BITS-1:0];
               end
            end
            OP_SEARCH, OP_DELETE: begin
               if (w.opcode == OP_SEARCH) n_search++;
               else n_delete++;
               if (live != 0) begin
                  slot = locate(v);
                  if (slot < live && entries[slot] == v) begin
                     r.status = ST_DONE;
                     r.position = slot[POS_BITS-1:0];
                     n_hit++;
                     if (w.opcode == OP_DELETE) begin
                        for (i = slot; i + 1 < live; i++) entries[i] = entries[i+1];
                        live--;
                        if (live == 0) n_empty_visits++;
                     end
                  end else begin
                     n_miss++;
                  end
               end else begin
                  n_miss++;
               end
            end
            default: n_unused++;
         endcase
         if (live > peak_fill) peak_fill = live;
         r.entry_count = live[COUNT_BITS-1:0];
         owed_q.push_back(r);
      endfunction

      // Compare one accepted response word with the oldest one owed.
      function void check_response(rsp_type got);
         rsp_type want;
         if (owed_q.size() == 0) begin
            $error("response word with none outstanding: %h", got);
            errors++;
            return;
         end
         want = owed_q.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
         if (got.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, got.position);
            errors++;
         end
         if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
            errors++;
         end
      endfunction

      function int pending();
         return owed_q.size();
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   table_scoreboard sb = new();

   logic [31:0] pool [POOL_SIZE];
   logic [31:0] extreme_values [4] = '{MIN_VALUE, MAX_VALUE, 32'h0, 32'hffff_ffff};
   bit          hold_request = 1'b0;
   bit          no_idle = 1'b0;
   int          words_sent = 0;
   int          idle_cycles = 0;

   sorted_table_insert_search_delete_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // Monitor both channels at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_data);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
      end
   end

   // Watchdog: too long without any word moving ends the run.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_sorted_table_insert_search_delete_unit: errors");
            $finish;
         end
      end
   end

   // Receiver: random ready bursts and stalls, plus one long hold-off on request.
   initial begin
      int cycles_left;
      cycles_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            cycles_left = LONG_HOLD;
         end else if (cycles_left > 0) begin
            cycles_left--;
         end else if ($urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            cycles_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 3);
         end else begin
            rsp_ready <= 1'b1;
            cycles_left = $urandom_range(0, 30);
         end
      end
   end

   // Sender gap: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   // Offer one request word after a gap and wait until it is taken.
   task automatic send_word(input logic [1:0] op, input logic [31:0] v);
      req_type w;
      int gap;
      w.opcode = op;
      w.operand_value = v;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      words_sent++;
   endtask

   // Stop offering words and wait until every owed response has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   // Most values come from a small pool so searches and deletes find matches.
   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return pool[$urandom_range(0, POOL_SIZE - 1)];
      if (r < 92) return $urandom;
      return extreme_values[$urandom_range(0, 3)];
   endfunction

   function automatic logic [1:0] pick_opcode(round_kind kind);
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) return OP_UNUSED;
      case (kind)
         ROUND_FILL:  return (r < 82) ? OP_INSERT : (r < 91) ? OP_SEARCH : OP_DELETE;
         ROUND_DRAIN: return (r < 20) ? OP_INSERT : (r < 42) ? OP_SEARCH : OP_DELETE;
         default:     return (r < 36) ? OP_INSERT : (r < 68) ? OP_SEARCH : OP_DELETE;
      endcase
   endfunction

   // Replace about half the pool with full-range or near-zero values.
   task automatic refresh_pool();
      int i;
      for (i = 0; i < POOL_SIZE; i++) begin
         if ($urandom_range(0, 1) == 0) begin
            if ($urandom_range(0, 1) == 0) pool[i] = $urandom;
            else pool[i] = 32'($signed($urandom_range(0, 40)) - 20);
         end
      end
   endtask

   // Directed words: empty table, extremes, duplicates, misses and the unused opcode.
   task automatic run_directed();
      send_word(OP_SEARCH, 32'd5);
      send_word(OP_DELETE, 32'd5);
      send_word(OP_UNUSED, 32'hffff_ffff);
      send_word(OP_INSERT, 32'h0);
      send_word(OP_INSERT, MAX_VALUE);
      send_word(OP_INSERT, MIN_VALUE);
      send_word(OP_INSERT, 32'hffff_ffff);
      send_word(OP_INSERT, 32'h0);
      send_word(OP_INSERT, 32'h0);
      send_word(OP_SEARCH, 32'h0);
      send_word(OP_SEARCH, MIN_VALUE);
      send_word(OP_SEARCH, MAX_VALUE);
      send_word(OP_SEARCH, 32'd1);
      send_word(OP_SEARCH, 32'h7fff_fffe);
      send_word(OP_DELETE, MAX_VALUE);
      send_word(OP_SEARCH, MAX_VALUE);
      send_word(OP_DELETE, MIN_VALUE);
      send_word(OP_DELETE, 32'h0);
      send_word(OP_DELETE, 32'd12345);
      send_word(OP_UNUSED, MAX_VALUE);
      send_word(OP_INSERT, 32'h5555_5555);
      send_word(OP_INSERT, 32'haaaa_aaaa);
   endtask

   // Main sequence: reset, directed words, then rounds of random words.
   initial begin
      round_kind kind;
      int round;
      int len;
      int k;
      int random_sent;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      for (k = 0; k < POOL_SIZE; k++) pool[k] = $urandom;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_directed();

      round = 0;
      random_sent = 0;
      while (random_sent < RANDOM_WORDS) begin
         case (round % 4)
            0:       kind = ROUND_FILL;
            1:       kind = ROUND_MIXED;
            2:       kind = ROUND_DRAIN;
            default: kind = round_kind'($urandom_range(0, 2));
         endcase
         if (kind == ROUND_FILL) refresh_pool();
         len = (kind == ROUND_FILL) ? $urandom_range(70, 120) : $urandom_range(30, 90);
         no_idle = (round % 5 == 3);
         // Starve the response side while words keep coming.
         if (round == 2) hold_request = 1'b1;
         // Let everything outstanding come back before going on.
         if (round == 4) wait_drained();
         for (k = 0; k < len && random_sent < RANDOM_WORDS; k++) begin
            send_word(pick_opcode(kind), pick_value());
            random_sent++;
         end
         round++;
      end
      no_idle = 1'b0;

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("covered %0d words: %0d insert, %0d search, %0d delete, %0d unused opcode",
               words_sent, sb.n_insert, sb.n_search, sb.n_delete, sb.n_unused);
      $display("matches %0d, misses %0d, full rejections %0d, peak fill %0d, emptied %0d times",
               sb.n_hit, sb.n_miss, sb.n_full, sb.peak_fill, sb.n_empty_visits);
      if (sb.errors == 0) begin
         $display("tb_sorted_table_insert_search_delete_unit: clean");
      end else begin
         $display("tb_sorted_table_insert_search_delete_unit: errors");
      end
      $finish;
   end

endmodule

>>> sorted_table_insert_search_delete_unit.f
sv/sti_pkg.sv
sv/sti_ram.sv
sv/sorted_table_insert_search_delete_unit.sv
tb/tb_sorted_table_insert_search_delete_unit.sv
